FILE: rtl/core/b32id_pkg.sv
`timescale 1ns / 1ps

package b32id_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned AccW  = 36;
  localparam int unsigned CharW = 7;
  localparam int unsigned CntW  = 3;
  localparam int unsigned DigW  = 5;

  typedef struct packed {
    logic       load;
    logic       emit;
    logic       emit_pfx;
    logic [1:0] pidx;
    logic       last;
    logic       finish;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic pfx;
    logic fin;
    logic seven;
    logic rem_nz;
  } dp_stat_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_PREFIX = 4'b0010,
    S_DIGIT  = 4'b0100,
    S_FLUSH  = 4'b1000
  } state_t;

  // Bits left over after cutting (32 + cnt) bits into 5-bit digits.
  function automatic logic [CntW-1:0] rem_bits(input logic [CntW-1:0] cnt);
    logic [CntW-1:0] r;
    unique case (cnt)
      3'd0:    r = 3'd2;
      3'd1:    r = 3'd3;
      3'd2:    r = 3'd4;
      3'd3:    r = 3'd0;
      3'd4:    r = 3'd1;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [CharW-1:0] b32_char(input logic [DigW-1:0] d);
    logic [CharW-1:0] c;
    if (d < 5'd26) begin
      c = 7'h41 + {2'b00, d};
    end else begin
      c = 7'h32 + {2'b00, d - 5'd26};
    end
    return c;
  endfunction

  function automatic logic [CharW-1:0] pfx_char(input logic [1:0] idx);
    logic [CharW-1:0] c;
    unique case (idx)
      2'd0:    c = 7'h53;
      2'd1:    c = 7'h54;
      2'd2:    c = 7'h4D;
      default: c = 7'h53;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/base32_id_encoder_top.sv
`timescale 1ns / 1ps

// Base32 identifier encoder. Each accepted beat carries one 32-bit identifier
// word, most significant byte first; the block turns the bit stream into
// base32 characters (A-Z, 2-7), one character beat per cycle while out_stall
// is low, after a three-character prefix at the start of each identifier. The
// beat marked final flushes leftover bits as one zero-padded digit and flags
// the last character; a one-word identifier drops its two leftover bits
// instead. A word passes an accept step, then three prefix characters or a
// turnaround state when no prefix is due, then its digits (six or seven, plus
// the flush digit on a final word that needs one), all through the single
// character output register. The next word is taken as soon as the last
// character of the current one is in that register, even if it is stalled.
module base32_id_encoder_top
  import b32id_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [WordW-1:0] in_uid_word,
  input  logic             in_final_word,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [CharW-1:0] out_character,
  output logic             out_last_char
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  b32id_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  b32id_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_uid_word   (in_uid_word),
    .in_final_word (in_final_word),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_character (out_character),
    .out_last_char (out_last_char),
    .cmd           (cmd),
    .stat          (stat)
  );

endmodule

FILE: rtl/core/b32id_dp.sv
`timescale 1ns / 1ps

module b32id_dp
  import b32id_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [WordW-1:0] in_uid_word,
  input  logic             in_final_word,
  input  logic             out_stall,
  output logic             out_valid,
  output logic [CharW-1:0] out_character,
  output logic             out_last_char,
  input  dp_cmd_t          cmd,
  output dp_stat_t         stat
);

  logic [AccW-1:0]  acc_r, acc_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic [3:0]       lo_r, lo_nxt;
  logic             at_start_r, at_start_nxt;
  logic             pfx_r, pfx_nxt;
  logic             fin_r, fin_nxt;
  logic             oval_r, oval_nxt;
  logic [CharW-1:0] ochar_r, ochar_nxt;
  logic             olast_r, olast_nxt;
  logic [CntW-1:0]  rem;

  assign rem = rem_bits(cnt_r);

  always_comb begin
    acc_nxt      = acc_r;
    cnt_nxt      = cnt_r;
    lo_nxt       = lo_r;
    at_start_nxt = at_start_r;
    pfx_nxt      = pfx_r;
    fin_nxt      = fin_r;
    oval_nxt     = oval_r;
    ochar_nxt    = ochar_r;
    olast_nxt    = olast_r;

    if (cmd.load) begin
      // Left-align the leftover bits and the new word so digits come off the top.
      acc_nxt      = {lo_r, in_uid_word} << (3'd4 - cnt_r);
      fin_nxt      = in_final_word;
      pfx_nxt      = at_start_r;
      at_start_nxt = 1'b0;
    end

    if (cmd.emit) begin
      oval_nxt  = 1'b1;
      olast_nxt = cmd.last;
      if (cmd.emit_pfx) begin
        ochar_nxt = pfx_char(cmd.pidx);
      end else begin
        ochar_nxt = b32_char(acc_r[AccW-1 -: DigW]);
        acc_nxt   = {acc_r[AccW-DigW-1:0], {DigW{1'b0}}};
      end
    end else if (!out_stall) begin
      oval_nxt = 1'b0;
    end

    if (cmd.finish) begin
      if (fin_r) begin
        cnt_nxt      = '0;
        lo_nxt       = '0;
        at_start_nxt = 1'b1;
      end else begin
        // The finishing digit is shifting out this cycle; keep what sits below it.
        cnt_nxt = rem;
        lo_nxt  = acc_r[AccW-DigW-1 -: 4] >> (3'd4 - rem);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      lo_r       <= '0;
      at_start_r <= 1'b1;
      oval_r     <= 1'b0;
    end else begin
      cnt_r      <= cnt_nxt;
      lo_r       <= lo_nxt;
      at_start_r <= at_start_nxt;
      oval_r     <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    pfx_r   <= pfx_nxt;
    fin_r   <= fin_nxt;
    ochar_r <= ochar_nxt;
    olast_r <= olast_nxt;
  end

  assign stat.out_free = !oval_r || !out_stall;
  assign stat.pfx      = pfx_r;
  assign stat.fin      = fin_r;
  assign stat.seven    = (cnt_r >= 3'd3);
  assign stat.rem_nz   = (rem != 3'd0);

  assign out_valid     = oval_r;
  assign out_character = ochar_r;
  assign out_last_char = olast_r;

endmodule

FILE: rtl/core/b32id_ctrl.sv
`timescale 1ns / 1ps

module b32id_ctrl
  import b32id_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t          state_r, state_nxt;
  logic [1:0]      pidx_r, pidx_nxt;
  logic [CntW-1:0] dcnt_r, dcnt_nxt;
  logic            dlast;

  assign in_stall = (state_r != S_IDLE);
  assign dlast    = (dcnt_r == (stat.seven ? 3'd6 : 3'd5));

  always_comb begin
    state_nxt = state_r;
    pidx_nxt  = pidx_r;
    dcnt_nxt  = dcnt_r;
    cmd       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          pidx_nxt  = 2'd0;
          dcnt_nxt  = 3'd0;
          state_nxt = S_PREFIX;
        end
      end
      S_PREFIX: begin
        if (!stat.pfx) begin
          state_nxt = S_DIGIT;
        end else if (stat.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_pfx = 1'b1;
          cmd.pidx     = pidx_r;
          pidx_nxt     = pidx_r + 2'd1;
          if (pidx_r == 2'd2) begin
            state_nxt = S_DIGIT;
          end
        end
      end
      S_DIGIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          dcnt_nxt = dcnt_r + 3'd1;
          if (dlast) begin
            // A one-word identifier drops its two leftover bits after the prefix.
            if (stat.fin && stat.rem_nz && !stat.pfx) begin
              state_nxt = S_FLUSH;
            end else begin
              cmd.last   = stat.fin;
              cmd.finish = 1'b1;
              state_nxt  = S_IDLE;
            end
          end
        end
      end
      S_FLUSH: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.last   = 1'b1;
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pidx_r  <= 2'd0;
      dcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pidx_r  <= pidx_nxt;
      dcnt_r  <= dcnt_nxt;
    end
  end

endmodule

FILE: verif/base32_id_checker.sv
`timescale 1ns / 1ps

module base32_id_checker
  import b32id_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [WordW-1:0] in_uid_word,
  input  logic             in_final_word,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [CharW-1:0] out_character,
  input  logic             out_last_char,
  output int               fail_count,
  output int               pending
);

  localparam int MaxCharsPerWord = 9;
  localparam logic [8*32-1:0] B32Alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";
  localparam logic [3*CharW-1:0] IdPrefix = {7'h53, 7'h54, 7'h4D};

  typedef struct packed {
    logic [CharW-1:0] code;
    logic             last;
  } id_char_t;

  id_char_t   expected_chars[$];
  id_char_t   want;
  logic [3:0] spare_bits;
  logic [2:0] spare_count;
  logic       prefix_due;
  int         mismatches = 0;
  int         queue_depth = 0;
  int         beat_no = 0;

  assign fail_count = mismatches;
  assign pending    = queue_depth;

  function automatic logic [CharW-1:0] digit_char(input logic [DigW-1:0] d);
    return B32Alphabet[8*(31 - int'(d)) +: CharW];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] character beat %0d: %s", $time, beat_no, msg);
    mismatches++;
  endtask

  task automatic push_char(inout int n, input logic [CharW-1:0] c);
    id_char_t entry;
    entry.code = c;
    entry.last = 1'b0;
    if (n < MaxCharsPerWord) begin
      expected_chars.push_back(entry);
      n++;
    end
  endtask

  // Appends the characters one word produces and advances the bit carry.
  task automatic encode_word(input logic [WordW-1:0] w, input logic fin);
    int unsigned     held;
    int unsigned     nbits;
    int              n;
    logic [AccW-1:0] acc;
    id_char_t        tail;
    held = (spare_count > 3'd4) ? 4 : int'(spare_count);
    acc = {spare_bits, w} & ((36'd1 << (32 + held)) - 36'd1);
    nbits = 32 + held;
    n = 0;
    if (prefix_due) begin
      for (int i = 0; i < 3; i++) push_char(n, IdPrefix[CharW*(2-i) +: CharW]);
      prefix_due = 1'b0;
    end
    while (nbits >= DigW) begin
      nbits -= DigW;
      push_char(n, digit_char(DigW'(acc >> nbits)));
    end
    if (fin) begin
      // A one-word identifier already fills all nine slots, so its two
      // leftover bits are dropped instead of flushed.
      if (nbits != 0 && n < MaxCharsPerWord) begin
        push_char(n, digit_char(DigW'(acc << (DigW - nbits))));
      end
      tail = expected_chars.pop_back();
      tail.last = 1'b1;
      expected_chars.push_back(tail);
      spare_bits  = '0;
      spare_count = '0;
      prefix_due  = 1'b1;
    end else begin
      spare_bits  = 4'(acc & ((36'd1 << nbits) - 36'd1));
      spare_count = 3'(nbits);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_chars.delete();
      spare_bits  = '0;
      spare_count = '0;
      prefix_due  = 1'b1;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected character 0x%02h", out_character));
        end else begin
          want = expected_chars.pop_front();
          if (out_character !== want.code) begin
            report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                      out_character, want.code));
          end
          if (out_last_char !== want.last) begin
            report_mismatch($sformatf("last flag %b, expected %b", out_last_char, want.last));
          end
        end
        beat_no++;
      end
      if (in_valid && !in_stall) begin
        encode_word(in_uid_word, in_final_word);
      end
    end
    queue_depth <= expected_chars.size();
  end

endmodule

FILE: verif/base32_id_encoder_top_tb.sv
`timescale 1ns / 1ps

module base32_id_encoder_top_tb;
  import b32id_pkg::*;

  localparam int ItemTarget  = 280;
  localparam int IdlePct     = 12;
  localparam int HoldCycles  = 150;
  localparam int DrainCycles = 24;
  localparam int DrainLimit  = 5000;
  localparam int CycleLimit  = 200000;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [WordW-1:0] in_uid_word;
  logic             in_final_word;
  logic             out_valid;
  logic             out_stall;
  logic [CharW-1:0] out_character;
  logic             out_last_char;

  int fail_count;
  int pending;
  int words_sent;
  int hold_asked;
  int hold_served;
  int cycle_count;
  bit quiet;

  always #5 clk = ~clk;

  base32_id_encoder_top uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_uid_word   (in_uid_word),
    .in_final_word (in_final_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last_char (out_last_char)
  );

  base32_id_checker id_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_uid_word   (in_uid_word),
    .in_final_word (in_final_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last_char (out_last_char),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  function automatic logic [WordW-1:0] corner_word(input int k);
    case (k % 6)
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'hAAAA_AAAA;
      3:       return 32'h5555_5555;
      4:       return 32'h8000_0001;
      default: return 32'h7FFF_FFFE;
    endcase
  endfunction

  // Returns at the edge where the beat was taken, so the next call can keep
  // valid high without a gap.
  task automatic send_word(input logic [WordW-1:0] w, input logic fin);
    while (!quiet && $urandom_range(99) < IdlePct) begin
      in_valid      <= 1'b0;
      in_uid_word   <= $urandom;
      in_final_word <= 1'($urandom);
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_uid_word   <= w;
    in_final_word <= fin;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // Character receiver: random stalls, or a long hold-off when one is asked.
  initial begin
    out_stall = 1'b0;
    hold_served = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_served != hold_asked) begin
        hold_served++;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < IdlePct);
        @(posedge clk);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int len;
    int pick;
    int waited;
    logic [WordW-1:0] w;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_uid_word   = '0;
    in_final_word = 1'b0;
    quiet         = 1'b0;
    hold_asked    = 0;
    words_sent    = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Identifiers of one to six words: the single-word case that drops its
    // tail bits, and every leftover count on the final word, zero included.
    for (int l = 1; l <= 6; l++) begin
      for (int k = 0; k < l; k++) begin
        send_word(corner_word(words_sent), k == l - 1);
      end
    end

    // The receiver holds off while words keep coming, so the block backs up.
    hold_asked++;
    while (words_sent < ItemTarget) begin
      quiet = (words_sent >= 130 && words_sent < 190);
      if (words_sent >= 230 && hold_asked < 2) hold_asked++;
      pick = $urandom_range(99);
      if (pick < 75) len = $urandom_range(7, 1);
      else if (pick < 95) len = $urandom_range(16, 8);
      else len = 40;
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(99) < 85) w = $urandom;
        else w = corner_word($urandom_range(5));
        send_word(w, k == len - 1);
      end
    end
    in_valid <= 1'b0;

    // The pending count is registered from the queue size, so let the last word's characters land first.
    @(posedge clk);
    waited = 0;
    while (pending != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
